>>> hdl/sdt_pkg.sv
// Shared types, constants and codes for the segment descriptor translator.
package sdt_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SEL_IDX_W     = 13;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int PAGE_SHIFT    = 12;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_XLATE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LIMIT = 1'b0,
    REG_PAGING      = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FAULT_OK      = 3'd0,
    FAULT_LOCAL   = 3'd1,
    FAULT_TABLE   = 3'd2,
    FAULT_NOWRITE = 3'd3,
    FAULT_NOEXEC  = 3'd4,
    FAULT_PRIV    = 3'd5,
    FAULT_LIMIT   = 3'd6
  } fault_t;

  // classified word passed from front to back
  typedef struct packed {
    func_t             func;
    logic              in_range;
    fault_t            pre_fault;
    logic [IDX_W-1:0]  index;
    logic [1:0]        rpl;
    logic [31:0]       offset;
    logic              is_write;
    logic              is_exec;
    logic [31:0]       desc_low_word;
    logic [31:0]       desc_high_word;
  } cmd_t;

endpackage

>>> hdl/segment_descriptor_translate.sv
// Top level of the segment descriptor translator.
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------------
//  input    | push / full            | func selector offset is_write is_exec
//           |                        | desc_low_word desc_high_word
//  result   | empty / pop            | linear_address fault
//  config   | cfg_valid / cfg_ready  | cfg_index cfg_data
//
//  One word per cycle sustained while every result is popped; an accepted word
//  goes through the queue, descriptor memory read and result register to the ports.
//  The single-port descriptor memory read sets the pace: one access per cycle.
//  Reset clears queue, pipeline and config registers; the table is not cleared.
//  A stalled result backs up the pipeline and the two-entry queue, then full rises.
module segment_descriptor_translate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            func,
  input  logic [15:0]                     selector,
  input  logic [31:0]                     offset,
  input  logic                            is_write,
  input  logic                            is_exec,
  input  logic [31:0]                     desc_low_word,
  input  logic [31:0]                     desc_high_word,
  output logic                            empty,
  input  logic                            pop,
  output logic [31:0]                     linear_address,
  output logic [2:0]                      fault,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sdt_pkg::*;

  logic [15:0] table_limit;
  logic        paging_enabled;
  cmd_t        front_cmd;
  cmd_t        q_head;
  logic        q_empty;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit    <= '0;
      paging_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TABLE_LIMIT: table_limit    <= cfg_data[15:0];
        REG_PAGING:      paging_enabled <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  sdt_front u_front (
    .func           (func),
    .selector       (selector),
    .offset         (offset),
    .is_write       (is_write),
    .is_exec        (is_exec),
    .desc_low_word  (desc_low_word),
    .desc_high_word (desc_high_word),
    .table_limit    (table_limit),
    .cmd            (front_cmd)
  );

  sdt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  sdt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .paging_enabled (paging_enabled),
    .pop            (pop),
    .empty          (empty),
    .linear_address (linear_address),
    .fault          (fault)
  );

endmodule

>>> hdl/sdt_front.sv
// Front end: selector decode and table-level checks ahead of the queue.
module sdt_front (
  input  logic                 func,
  input  logic [15:0]          selector,
  input  logic [31:0]          offset,
  input  logic                 is_write,
  input  logic                 is_exec,
  input  logic [31:0]          desc_low_word,
  input  logic [31:0]          desc_high_word,
  input  logic [15:0]          table_limit,
  output sdt_pkg::cmd_t        cmd
);
  import sdt_pkg::*;

  logic [SEL_IDX_W-1:0] sel_index;
  logic [16:0]          byte_pos;
  logic [16:0]          limit_p1;
  logic                 in_range;
  logic                 tbl_fault;

  assign sel_index = selector[15:3];
  assign byte_pos  = {1'b0, sel_index, 3'b000};
  assign limit_p1  = {1'b0, table_limit} + 17'd1;
  assign in_range  = ({1'b0, sel_index} < (SEL_IDX_W + 1)'(TABLE_ENTRIES));
  assign tbl_fault = (byte_pos > limit_p1) || !in_range;

  always_comb begin
    cmd.func           = func_t'(func);
    cmd.in_range       = in_range;
    cmd.index          = sel_index[IDX_W-1:0];
    cmd.rpl            = selector[1:0];
    cmd.offset         = offset;
    cmd.is_write       = is_write;
    cmd.is_exec        = is_exec;
    cmd.desc_low_word  = desc_low_word;
    cmd.desc_high_word = desc_high_word;
    if (selector[2]) begin
      cmd.pre_fault = FAULT_LOCAL;
    end else if (tbl_fault) begin
      cmd.pre_fault = FAULT_TABLE;
    end else begin
      cmd.pre_fault = FAULT_OK;
    end
  end

endmodule

>>> hdl/sdt_queue.sv
// Short queue of classified words between front and back.
module sdt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  sdt_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd,
  output sdt_pkg::cmd_t  rd_data,
  output logic           empty
);
  import sdt_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/sdt_back.sv
// Back end: descriptor memory, descriptor checks and result register.
module sdt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  sdt_pkg::cmd_t        q_head,
  output logic                 q_pop,
  input  logic                 paging_enabled,
  input  logic                 pop,
  output logic                 empty,
  output logic [31:0]          linear_address,
  output logic [2:0]           fault
);
  import sdt_pkg::*;

  logic [63:0] mem [TABLE_ENTRIES];
  logic [63:0] rdata;
  cmd_t        b_cmd;
  logic        b_valid;
  logic        b_adv;
  logic        out_valid;

  logic [31:0] lo;
  logic [31:0] hi;
  logic [19:0] lim20;
  logic [31:0] lim;
  logic [31:0] base;
  fault_t      res_fault;
  logic [31:0] res_addr;

  assign b_adv = b_valid && (!out_valid || pop);
  assign q_pop = !q_empty && (!b_valid || b_adv);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop && q_head.func == FUNC_WRITE && q_head.in_range) begin
      mem[q_head.index] <= {q_head.desc_high_word, q_head.desc_low_word};
    end
    if (q_pop) begin
      rdata <= mem[q_head.index];
      b_cmd <= q_head;
    end
  end

  assign lo    = rdata[31:0];
  assign hi    = rdata[63:32];
  assign lim20 = {hi[19:16], lo[15:0]};
  assign lim   = hi[23] ? {lim20, PAGE_SHIFT'(0)} : {12'd0, lim20};
  assign base  = {hi[31:24], hi[7:0], lo[31:16]};

  // access byte is hi[15:8]: writable bit 1, executable bit 3, DPL bits 6:5
  always_comb begin
    res_fault = FAULT_OK;
    res_addr  = '0;
    if (b_cmd.func == FUNC_XLATE) begin
      if (b_cmd.pre_fault != FAULT_OK) begin
        res_fault = b_cmd.pre_fault;
      end else if (b_cmd.is_write && !hi[9]) begin
        res_fault = FAULT_NOWRITE;
      end else if (b_cmd.is_exec && !hi[11]) begin
        res_fault = FAULT_NOEXEC;
      end else if (hi[14:13] < b_cmd.rpl) begin
        res_fault = FAULT_PRIV;
      end else if (!paging_enabled && (b_cmd.offset > lim)) begin
        res_fault = FAULT_LIMIT;
      end else begin
        res_addr = base + b_cmd.offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      linear_address <= res_addr;
      fault          <= res_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
